FILE: rtl/core/fcsl_pkg.sv
// Shared types, constants and helpers for the FAT chain slack locator.
// No dependencies; imported by the modulo unit, the checker and the top level.
`timescale 1ns / 1ps

package fcsl_pkg;

    // Default table depth (entries of 32 bits)
    localparam int unsigned TABLE_ENTRIES_DEF = 65536;

    // Field widths fixed by the interface
    localparam int BPS_W   = 13;
    localparam int SPC_W   = 8;
    localparam int CSIZE_W = BPS_W + SPC_W;
    localparam int LEN_W   = 17;
    localparam int OFS_W   = 48;
    localparam int SLK_W   = 19;

    // Register reset values
    localparam logic [BPS_W-1:0] BPS_RESET = 13'd512;
    localparam logic [SPC_W-1:0] SPC_RESET = 8'd8;
    localparam logic [31:0]      FDS_RESET = 32'd0;
    localparam logic [31:0]      EOC_RESET = 32'd268435448;

    // Cluster 2 is the first data cluster
    localparam logic [31:0] FIRST_DATA_CLUSTER = 32'd2;

    // Saturation limit of the 19-bit slack fields
    localparam logic [SLK_W-1:0] SLK_MAX = {SLK_W{1'b1}};

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_BPS = 2'd0,
        REG_SPC = 2'd1,
        REG_FDS = 2'd2,
        REG_EOC = 2'd3
    } reg_idx_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_LOCATED  = 2'd0,
        ST_WRITTEN  = 2'd1,
        ST_TOO_LONG = 2'd2,
        ST_INVALID  = 2'd3
    } status_t;

    // Item kinds
    typedef enum logic {
        ACT_WRITE  = 1'b0,
        ACT_LOCATE = 1'b1
    } action_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_READ,
        S_MUL_SECTOR,
        S_MUL_BYTES,
        S_DIV_WAIT,
        S_RESULT
    } state_t;

    // Request to the modulo unit
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    // Status from the modulo unit
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Clamp a cluster-sized value to the 19-bit result range
    function automatic logic [SLK_W-1:0] sat_slk(input logic [CSIZE_W-1:0] v);
        logic [SLK_W-1:0] r;
        if (v > CSIZE_W'(SLK_MAX))
            r = SLK_MAX;
        else
            r = v[SLK_W-1:0];
        return r;
    endfunction

endpackage

FILE: rtl/core/fcsl_table.sv
// Allocation table store: one write port, one registered read port.
// Depends on nothing but the clock; contents are undefined until written.
`timescale 1ns / 1ps

module fcsl_table #(
    parameter int unsigned ENTRIES = 65536,
    parameter int          IDX_W   = 16
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [31:0]      wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [31:0]      rd_data
);

    logic [31:0] mem [ENTRIES];
    logic [31:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/fcsl_modulo.sv
// Iterative restoring modulo unit: one remainder bit per cycle.
// Depends on fcsl_pkg. A zero divisor gives a zero remainder.
`timescale 1ns / 1ps

module fcsl_modulo (
    input  logic                           clk,
    input  logic                           rst_n,
    input  fcsl_pkg::div_ctrl_t            ctrl,
    input  logic [31:0]                    dividend,
    input  logic [fcsl_pkg::CSIZE_W-1:0]   divisor,
    output fcsl_pkg::div_stat_t            stat,
    output logic [fcsl_pkg::CSIZE_W-1:0]   remainder
);

    import fcsl_pkg::*;

    logic               busy_reg,  busy_next;
    logic               done_reg,  done_next;
    logic [4:0]         step_reg,  step_next;
    logic [31:0]        dvd_reg,   dvd_next;
    logic [CSIZE_W-1:0] dvs_reg,   dvs_next;
    logic [CSIZE_W-1:0] rem_reg,   rem_next;
    logic [CSIZE_W:0]   trial;

    // one compare-and-subtract step
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[31]};
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
                rem_next = CSIZE_W'(trial - {1'b0, dvs_reg});
            else
                rem_next = trial[CSIZE_W-1:0];
            dvd_next  = {dvd_reg[30:0], 1'b0};
            step_next = step_reg + 5'd1;
            if (step_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign remainder = (dvs_reg == '0) ? '0 : rem_reg;

endmodule

FILE: rtl/core/fat_chain_slack_locator.sv
// Top level of the FAT chain slack locator: APB registers, sequencer, table, modulo unit.
// Depends on fcsl_pkg, fcsl_table and fcsl_modulo.
`timescale 1ns / 1ps

// A word is taken when start is high and busy low; busy stays high until its
// result has been shown. Every word gives exactly one result, on the result
// ports for the single cycle in which done is high; the receiver cannot hold
// it off and must take it then. A table write goes from idle straight to the
// result state. A locate takes a table check, then the registered table read,
// for each cluster in the chain, then the closing steps: the sector and byte
// multiplies and a wait for the 32-step modulo by the cluster size; a bad cluster
// or an over-long chain ends the walk at once. Table entries hold nothing until
// written and must be written before a chain reaches them. Registers are to be
// written over APB only while the block is idle; the block does not enforce it.
module fat_chain_slack_locator #(
    parameter int unsigned TABLE_ENTRIES = fcsl_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // APB register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [3:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // command side
    input  logic                           start,
    output logic                           busy,
    input  logic                           action,
    input  logic [15:0]                    entry_index,
    input  logic [31:0]                    entry_value,
    input  logic [31:0]                    first_cluster,
    input  logic [31:0]                    file_size,
    // result side
    output logic                           done,
    output logic [1:0]                     status,
    output logic [31:0]                    last_cluster,
    output logic [fcsl_pkg::LEN_W-1:0]     chain_length,
    output logic [fcsl_pkg::OFS_W-1:0]     slack_byte_offset,
    output logic [fcsl_pkg::SLK_W-1:0]     slack_bytes,
    output logic [fcsl_pkg::SLK_W-1:0]     slack_offset_in_cluster
);

    import fcsl_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [32:0]      TE_LIM  = 33'(TABLE_ENTRIES);
    localparam logic [CNT_W-1:0] CNT_LIM = CNT_W'(TABLE_ENTRIES);

    // configuration registers
    logic [BPS_W-1:0] bps_reg;
    logic [SPC_W-1:0] spc_reg;
    logic [31:0]      fds_reg;
    logic [31:0]      eoc_reg;
    logic             cfg_wr;
    reg_idx_t         cfg_sel;

    // sequencer
    state_t state_reg, state_next;

    // working registers
    logic [31:0]       cluster_reg,  cluster_next;
    logic [31:0]       size_reg,     size_next;
    logic [CNT_W-1:0]  count_reg,    count_next;
    logic [40:0]       sector_reg,   sector_next;
    logic [OFS_W-1:0]  bytes_reg,    bytes_next;

    // result registers
    status_t           res_status_reg, res_status_next;
    logic [31:0]       res_last_reg,   res_last_next;
    logic [LEN_W-1:0]  res_len_reg,    res_len_next;
    logic [OFS_W-1:0]  res_ofs_reg,    res_ofs_next;
    logic [SLK_W-1:0]  res_slk_reg,    res_slk_next;
    logic [SLK_W-1:0]  res_within_reg, res_within_next;

    // table and modulo unit hookup
    logic              accept;
    logic              wr_en;
    logic              wr_in_range;
    logic [IDX_W+15:0] wr_idx_ext;
    logic              rd_en;
    logic [31:0]       rd_data;
    logic              cluster_ok;
    logic [CSIZE_W-1:0] csize;
    logic [CSIZE_W-1:0] clu_rem;
    logic [CSIZE_W-1:0] slack_full;
    logic [CNT_W+LEN_W-1:0] count_ext;
    logic [31:0]       clu_rel;
    logic [39:0]       clu_x_spc;
    logic [53:0]       sec_x_bps;
    div_ctrl_t         div_ctrl;
    div_stat_t         div_stat;

    // APB register file
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bps_reg <= BPS_RESET;
            spc_reg <= SPC_RESET;
            fds_reg <= FDS_RESET;
            eoc_reg <= EOC_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                REG_BPS: bps_reg <= pwdata[BPS_W-1:0];
                REG_SPC: spc_reg <= pwdata[SPC_W-1:0];
                REG_FDS: fds_reg <= pwdata;
                REG_EOC: eoc_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_BPS: prdata = 32'(bps_reg);
            REG_SPC: prdata = 32'(spc_reg);
            REG_FDS: prdata = fds_reg;
            REG_EOC: prdata = eoc_reg;
            default: prdata = '0;
        endcase
    end

    // handshake and table ports
    assign accept      = start && !busy;
    assign wr_in_range = 33'(entry_index) < TE_LIM;
    assign wr_idx_ext  = {{IDX_W{1'b0}}, entry_index};
    assign wr_en       = accept && (action == ACT_WRITE) && wr_in_range;
    assign cluster_ok  = (cluster_reg >= FIRST_DATA_CLUSTER) && ({1'b0, cluster_reg} < TE_LIM);
    assign rd_en       = (state_reg == S_CHECK) && cluster_ok;

    fcsl_table #(
        .ENTRIES (TABLE_ENTRIES),
        .IDX_W   (IDX_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_idx_ext[IDX_W-1:0]),
        .wr_data (entry_value),
        .rd_en   (rd_en),
        .rd_addr (cluster_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // cluster size and modulo unit
    assign csize = CSIZE_W'(bps_reg) * CSIZE_W'(spc_reg);

    assign div_ctrl.start = (state_reg == S_READ) && (rd_data >= eoc_reg);

    fcsl_modulo u_modulo (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .dividend  (size_reg),
        .divisor   (csize),
        .stat      (div_stat),
        .remainder (clu_rem)
    );

    // closing arithmetic, one multiply per state
    assign clu_rel    = cluster_reg - FIRST_DATA_CLUSTER;
    assign clu_x_spc  = 40'(clu_rel) * 40'(spc_reg);
    assign sec_x_bps  = 54'(sector_reg) * 54'(bps_reg);
    assign slack_full = (clu_rem == '0) ? '0 : CSIZE_W'(csize - clu_rem);
    assign count_ext  = {{LEN_W{1'b0}}, count_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = (action == ACT_LOCATE) ? S_CHECK : S_RESULT;
            end
            S_CHECK:
            begin
                state_next = cluster_ok ? S_READ : S_RESULT;
            end
            S_READ:
            begin
                priority if (rd_data >= eoc_reg)
                    state_next = S_MUL_SECTOR;
                else if (count_reg >= CNT_LIM)
                    state_next = S_RESULT;
                else
                    state_next = S_CHECK;
            end
            S_MUL_SECTOR: state_next = S_MUL_BYTES;
            S_MUL_BYTES:  state_next = S_DIV_WAIT;
            S_DIV_WAIT:
            begin
                if (div_stat.done)
                    state_next = S_RESULT;
            end
            S_RESULT:     state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    // datapath and result updates
    always_comb
    begin
        cluster_next    = cluster_reg;
        size_next       = size_reg;
        count_next      = count_reg;
        sector_next     = sector_reg;
        bytes_next      = bytes_reg;
        res_status_next = res_status_reg;
        res_last_next   = res_last_reg;
        res_len_next    = res_len_reg;
        res_ofs_next    = res_ofs_reg;
        res_slk_next    = res_slk_reg;
        res_within_next = res_within_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cluster_next    = first_cluster;
                    size_next       = file_size;
                    count_next      = '0;
                    res_status_next = wr_in_range ? ST_WRITTEN : ST_INVALID;
                    res_last_next   = '0;
                    res_len_next    = '0;
                    res_ofs_next    = '0;
                    res_slk_next    = '0;
                    res_within_next = '0;
                end
            end
            S_CHECK:
            begin
                if (cluster_ok)
                    count_next = count_reg + CNT_W'(1);
                else
                    res_status_next = ST_INVALID;
            end
            S_READ:
            begin
                priority if (rd_data >= eoc_reg)
                    res_status_next = ST_LOCATED;
                else if (count_reg >= CNT_LIM)
                    res_status_next = ST_TOO_LONG;
                else
                    cluster_next = rd_data;
            end
            S_MUL_SECTOR:
            begin
                sector_next = 41'(clu_x_spc) + 41'(fds_reg);
            end
            S_MUL_BYTES:
            begin
                bytes_next = sec_x_bps[OFS_W-1:0];
            end
            S_DIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    res_last_next   = cluster_reg;
                    res_len_next    = count_ext[LEN_W-1:0];
                    res_ofs_next    = OFS_W'(bytes_reg + OFS_W'(clu_rem));
                    res_slk_next    = sat_slk(slack_full);
                    res_within_next = sat_slk(clu_rem);
                end
            end
            S_RESULT: ;
            default: ;
        endcase
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cluster_reg    <= cluster_next;
        size_reg       <= size_next;
        count_reg      <= count_next;
        sector_reg     <= sector_next;
        bytes_reg      <= bytes_next;
        res_status_reg <= res_status_next;
        res_last_reg   <= res_last_next;
        res_len_reg    <= res_len_next;
        res_ofs_reg    <= res_ofs_next;
        res_slk_reg    <= res_slk_next;
        res_within_reg <= res_within_next;
    end

    // result ports
    assign busy                    = (state_reg != S_IDLE);
    assign done                    = (state_reg == S_RESULT);
    assign status                  = res_status_reg;
    assign last_cluster            = res_last_reg;
    assign chain_length            = res_len_reg;
    assign slack_byte_offset       = res_ofs_reg;
    assign slack_bytes             = res_slk_reg;
    assign slack_offset_in_cluster = res_within_reg;

endmodule

FILE: rtl/core/fcsl_checker.sv
// Port-level checks for the FAT chain slack locator, bound to the top level.
// Depends on fcsl_pkg and fat_chain_slack_locator.
`timescale 1ns / 1ps

module fcsl_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         done,
    input logic [1:0]                   status,
    input logic [31:0]                  last_cluster,
    input logic [fcsl_pkg::LEN_W-1:0]   chain_length,
    input logic [fcsl_pkg::SLK_W-1:0]   slack_bytes,
    input logic [fcsl_pkg::SLK_W-1:0]   slack_offset_in_cluster
);

    import fcsl_pkg::*;

    // a result only appears while a word is in hand
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe outside a busy period");

    // one word in flight: never two results in a row
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held over two cycles");

    // an accepted word keeps the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after taking a word");

    // non-locate results carry zero payload
    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_LOCATED)) |->
            (last_cluster == '0 && chain_length == '0 &&
             slack_bytes == '0 && slack_offset_in_cluster == '0))
        else $error("non-zero payload on a write or error result");

    // a located chain has at least one valid data cluster
    a_located_chain: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_LOCATED)) |->
            (chain_length != '0 && last_cluster >= FIRST_DATA_CLUSTER))
        else $error("located result with an empty or invalid chain");

endmodule

bind fat_chain_slack_locator fcsl_checker u_fcsl_checker (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .start                   (start),
    .busy                    (busy),
    .done                    (done),
    .status                  (status),
    .last_cluster            (last_cluster),
    .chain_length            (chain_length),
    .slack_bytes             (slack_bytes),
    .slack_offset_in_cluster (slack_offset_in_cluster)
);

FILE: bench/fat_chain_slack_locator_test.sv
// Self-checking bench for fat_chain_slack_locator: register access, directed chain walks,
// an over-long loop and randomised table traffic over several cluster geometries.
// Depends on fcsl_pkg and the fat_chain_slack_locator RTL only.
`timescale 1ns / 1ps

module fat_chain_slack_locator_test;

    import fcsl_pkg::*;

    localparam int unsigned FAT_DEPTH      = TABLE_ENTRIES_DEF;
    localparam int          MAX_SAFE_HOPS  = 64;
    localparam int          WATCHDOG_LIMIT = 600000;
    localparam logic [63:0] OFS_MASK       = 64'h0000_FFFF_FFFF_FFFF;

    // One expected result word
    typedef struct packed {
        status_t             st;
        logic [31:0]         last;
        logic [LEN_W-1:0]    len;
        logic [OFS_W-1:0]    ofs;
        logic [SLK_W-1:0]    spare;
        logic [SLK_W-1:0]    clu_rem;
    } slack_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic        start = 1'b0;
    logic        busy;
    logic        action = 1'b0;
    logic [15:0] entry_index = '0;
    logic [31:0] entry_value = '0;
    logic [31:0] first_cluster = '0;
    logic [31:0] file_size = '0;

    logic              done;
    logic [1:0]        status;
    logic [31:0]       last_cluster;
    logic [LEN_W-1:0]  chain_length;
    logic [OFS_W-1:0]  slack_byte_offset;
    logic [SLK_W-1:0]  slack_bytes;
    logic [SLK_W-1:0]  slack_offset_in_cluster;

    // Shadow of the allocation table and the geometry registers
    logic [31:0]     fat_copy [0:FAT_DEPTH-1];
    bit              fat_written [0:FAT_DEPTH-1];
    logic [31:0]     written_heads [$];
    logic [BPS_W-1:0] bps_q = BPS_RESET;
    logic [SPC_W-1:0] spc_q = SPC_RESET;
    logic [31:0]     fds_q = FDS_RESET;
    logic [31:0]     eoc_q = EOC_RESET;

    slack_report_t   expected_reports [$];
    int              mismatches = 0;
    int              words_sent = 0;
    int              quiet_cycles = 0;
    bit              pauses_on = 1'b1;

    fat_chain_slack_locator i_dut (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .psel                    (psel),
        .penable                 (penable),
        .pwrite                  (pwrite),
        .paddr                   (paddr),
        .pwdata                  (pwdata),
        .prdata                  (prdata),
        .pready                  (pready),
        .start                   (start),
        .busy                    (busy),
        .action                  (action),
        .entry_index             (entry_index),
        .entry_value             (entry_value),
        .first_cluster           (first_cluster),
        .file_size               (file_size),
        .done                    (done),
        .status                  (status),
        .last_cluster            (last_cluster),
        .chain_length            (chain_length),
        .slack_byte_offset       (slack_byte_offset),
        .slack_bytes             (slack_bytes),
        .slack_offset_in_cluster (slack_offset_in_cluster)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Walk the shadow table from head and work out the locate result
    function automatic slack_report_t locate_slack(input logic [31:0] head,
                                                   input logic [31:0] size);
        slack_report_t rep;
        logic [63:0]   cl, visits, csize, clu_rem, spare, sector, ofs;
        logic [31:0]   link;
        bit            walking;
        rep = '0;
        rep.st = ST_LOCATED;
        cl = 64'(head);
        visits = 0;
        walking = 1'b1;
        while (walking)
        begin
            if (cl < 64'(FIRST_DATA_CLUSTER) || cl >= 64'(FAT_DEPTH))
            begin
                rep.st = ST_INVALID;
                walking = 1'b0;
            end
            else
            begin
                visits = visits + 1;
                link = fat_copy[cl[15:0]];
                if (link >= eoc_q)
                    walking = 1'b0;
                else if (visits >= 64'(FAT_DEPTH))
                begin
                    rep.st = ST_TOO_LONG;
                    walking = 1'b0;
                end
                else
                    cl = 64'(link);
            end
        end
        if (rep.st == ST_LOCATED)
        begin
            csize = 64'(bps_q) * 64'(spc_q);
            clu_rem = 0;
            spare = 0;
            if (csize != 0)
            begin
                clu_rem = 64'(size) % csize;
                spare = (clu_rem == 0) ? 64'd0 : csize - clu_rem;
            end
            sector = (cl - 64'(FIRST_DATA_CLUSTER)) * 64'(spc_q) + 64'(fds_q);
            ofs = ((sector * 64'(bps_q)) & OFS_MASK) + clu_rem;
            rep.last = cl[31:0];
            rep.len = visits[LEN_W-1:0];
            rep.ofs = ofs[OFS_W-1:0];
            rep.spare = (spare > 64'(SLK_MAX)) ? SLK_MAX : spare[SLK_W-1:0];
            rep.clu_rem = (clu_rem > 64'(SLK_MAX)) ? SLK_MAX : clu_rem[SLK_W-1:0];
        end
        return rep;
    endfunction

    // True when a walk from head reads only written entries and ends soon
    function automatic bit chain_is_safe(input logic [31:0] head);
        logic [31:0] cl;
        int          hops;
        bit          verdict, walking;
        cl = head;
        hops = 0;
        verdict = 1'b0;
        walking = 1'b1;
        while (walking)
        begin
            if (cl < FIRST_DATA_CLUSTER || cl >= FAT_DEPTH)
            begin
                verdict = 1'b1;
                walking = 1'b0;
            end
            else if (!fat_written[cl[15:0]])
                walking = 1'b0;
            else if (fat_copy[cl[15:0]] >= eoc_q)
            begin
                verdict = 1'b1;
                walking = 1'b0;
            end
            else if (hops >= MAX_SAFE_HOPS)
                walking = 1'b0;
            else
            begin
                hops++;
                cl = fat_copy[cl[15:0]];
            end
        end
        return verdict;
    endfunction

    function automatic logic [31:0] register_image(input reg_idx_t ri);
        logic [31:0] img;
        case (ri)
            REG_BPS: img = 32'(bps_q);
            REG_SPC: img = 32'(spc_q);
            REG_FDS: img = fds_q;
            default: img = eoc_q;
        endcase
        return img;
    endfunction

    // Mostly a small pool so that chains interlink, sometimes anywhere or a table end
    function automatic logic [31:0] pick_cluster();
        int pick;
        logic [31:0] cl;
        pick = $urandom_range(99);
        if (pick < 70)
            cl = $urandom_range(257, 2);
        else if (pick < 95)
            cl = $urandom_range(FAT_DEPTH - 1, 2);
        else
            cl = ($urandom_range(1) == 0) ? 32'd2 : 32'(FAT_DEPTH - 1);
        return cl;
    endfunction

    function automatic logic [31:0] pick_end_value();
        int pick;
        logic [31:0] v;
        pick = $urandom_range(99);
        if (pick < 40)
            v = 32'hFFFF_FFFF;
        else if (pick < 70)
            v = eoc_q;
        else
            v = $urandom_range(32'hFFFF_FFFF, eoc_q);
        return v;
    endfunction

    function automatic logic [31:0] pick_cluster_outside();
        logic [31:0] cl;
        if ($urandom_range(1) == 0)
            cl = $urandom_range(1, 0);
        else
            cl = $urandom_range(32'hFFFF_FFFF, FAT_DEPTH);
        return cl;
    endfunction

    // Exact cluster fills, sizes near one cluster, anything, and the extremes
    function automatic logic [31:0] pick_file_size();
        int pick;
        logic [31:0] csize, sz;
        csize = 32'(bps_q) * 32'(spc_q);
        pick = $urandom_range(99);
        if (pick < 30 && csize != 0)
            sz = csize * $urandom_range(4096, 0);
        else if (pick < 50)
            sz = $urandom_range(2 * csize + 1, 0);
        else if (pick < 90)
            sz = $urandom;
        else
            sz = ($urandom_range(1) == 0) ? 32'd0 : 32'hFFFF_FFFF;
        return sz;
    endfunction

    // Random sender gap: mostly none or short, a few long
    task automatic sender_pause();
        int pick, gap;
        pick = $urandom_range(99);
        gap = 0;
        if (pauses_on)
        begin
            if (pick >= 55 && pick < 85)
                gap = $urandom_range(3, 1);
            else if (pick >= 85 && pick < 97)
                gap = $urandom_range(12, 4);
            else if (pick >= 97)
                gap = $urandom_range(60, 20);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Offer one word, wait for it to be taken, then log what it must produce
    task automatic send_word(input action_t act, input logic [15:0] idx, input logic [31:0] val,
                             input logic [31:0] head, input logic [31:0] size);
        slack_report_t rep;
        start <= 1'b1;
        action <= act;
        entry_index <= idx;
        entry_value <= val;
        first_cluster <= head;
        file_size <= size;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        if (act == ACT_WRITE)
        begin
            if (!fat_written[idx])
                written_heads.insert(written_heads.size(), 32'(idx));
            fat_copy[idx] = val;
            fat_written[idx] = 1'b1;
            rep = '0;
            rep.st = ST_WRITTEN;
        end
        else
            rep = locate_slack(head, size);
        expected_reports.insert(expected_reports.size(), rep);
        words_sent++;
        sender_pause();
    endtask

    task automatic send_write(input logic [15:0] idx, input logic [31:0] val);
        send_word(ACT_WRITE, idx, val, $urandom, $urandom);
    endtask

    task automatic send_locate(input logic [31:0] head, input logic [31:0] size);
        send_word(ACT_LOCATE, 16'($urandom), $urandom, head, size);
    endtask

    // Locate from head if the walk stays on written entries, else a bad cluster
    task automatic locate_or_reject(input logic [31:0] head, input logic [31:0] size);
        if (chain_is_safe(head))
            send_locate(head, size);
        else
            send_locate(pick_cluster_outside(), size);
    endtask

    task automatic compare_field(input string what, input logic [63:0] want_v,
                                 input logic [63:0] got_v);
        if (got_v !== want_v)
        begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, what, want_v, got_v);
        end
    endtask

    // APB read, checked against the shadow register
    task automatic read_register(input reg_idx_t ri);
        logic [31:0] want;
        want = register_image(ri);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {ri, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        compare_field($sformatf("register at %0h", {ri, 2'b00}), 64'(want), 64'(prdata));
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // APB write, then read it back
    task automatic program_register(input reg_idx_t ri, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {ri, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (ri)
            REG_BPS: bps_q = value[BPS_W-1:0];
            REG_SPC: spc_q = value[SPC_W-1:0];
            REG_FDS: fds_q = value;
            default: eoc_q = value;
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        read_register(ri);
    endtask

    // Let every outstanding word come back before touching registers
    task automatic drain_block();
        start <= 1'b0;
        @(posedge clk);
        while (expected_reports.size() != 0 || busy !== 1'b0)
            @(posedge clk);
    endtask

    // Write a chain of random clusters, then locate from its head
    task automatic build_and_locate_chain();
        logic [31:0] links [$];
        logic [31:0] tail;
        int          len, k;
        len = ($urandom_range(9) == 0) ? $urandom_range(20, 7) : $urandom_range(6, 1);
        repeat (len) links.insert(links.size(), pick_cluster());
        for (k = 0; k < len - 1; k++)
            send_write(links[k][15:0], links[k + 1]);
        // a tenth of chains end on a random word: broken or dangling
        tail = ($urandom_range(9) == 0) ? $urandom : pick_end_value();
        send_write(links[len - 1][15:0], tail);
        locate_or_reject(links[0], pick_file_size());
    endtask

    // One random step of table traffic
    task automatic random_step();
        int pick, sel;
        logic [15:0] idx;
        logic [31:0] val;
        pick = $urandom_range(99);
        if (pick < 45)
            build_and_locate_chain();
        else if (pick < 60 && written_heads.size() != 0)
            locate_or_reject(written_heads[$urandom_range(written_heads.size() - 1)],
                             pick_file_size());
        else if (pick < 68)
            send_locate(pick_cluster_outside(), pick_file_size());
        else
        begin
            sel = $urandom_range(99);
            if (sel < 60)
                idx = pick_cluster();
            else if (sel < 95)
                idx = 16'($urandom);
            else
                idx = ($urandom_range(1) == 0) ? 16'($urandom_range(1, 0)) : 16'hFFFF;
            sel = $urandom_range(99);
            if (sel < 40)
                val = pick_end_value();
            else if (sel < 70)
                val = pick_cluster();
            else if (sel < 90)
                val = $urandom;
            else
                val = $urandom_range(1, 0);
            send_write(idx, val);
        end
    endtask

    task automatic run_phase(input logic [31:0] bps, input logic [31:0] spc,
                             input logic [31:0] fds, input logic [31:0] eoc,
                             input int count, input bit with_pauses);
        int target;
        drain_block();
        program_register(REG_BPS, bps);
        program_register(REG_SPC, spc);
        program_register(REG_FDS, fds);
        program_register(REG_EOC, eoc);
        pauses_on = with_pauses;
        target = words_sent + count;
        while (words_sent < target)
            random_step();
    endtask

    // Reset values, extremes, masking of wide writes, then back to reset values
    task automatic test_register_access();
        read_register(REG_BPS);
        read_register(REG_SPC);
        read_register(REG_FDS);
        read_register(REG_EOC);
        program_register(REG_BPS, 32'hFFFF_FFFF);
        program_register(REG_SPC, 32'hFFFF_FFFF);
        program_register(REG_FDS, 32'hFFFF_FFFF);
        program_register(REG_EOC, 32'h0);
        program_register(REG_BPS, 32'h0);
        program_register(REG_SPC, 32'h0);
        program_register(REG_BPS, 32'(BPS_RESET));
        program_register(REG_SPC, 32'(SPC_RESET));
        program_register(REG_FDS, FDS_RESET);
        program_register(REG_EOC, EOC_RESET);
    endtask

    // Field extremes and the invalid-cluster cases, 4 KiB clusters
    task automatic test_directed_items();
        pauses_on = 1'b1;
        send_write(16'h0000, 32'hFFFF_FFFF);
        send_write(16'hFFFF, EOC_RESET);
        send_locate(32'(FAT_DEPTH - 1), 32'd0);
        send_write(16'd2, 32'd3);
        send_write(16'd3, 32'hFFFF_FFFF);
        // file exactly fills its last cluster: no slack
        send_locate(32'd2, 32'd4096);
        send_locate(32'd2, 32'd4097);
        send_locate(32'd2, 32'd1);
        send_locate(32'd3, 32'hFFFF_FFFF);
        // first cluster outside the table or below the first data cluster
        send_locate(32'd0, 32'd100);
        send_locate(32'd1, 32'd100);
        send_locate(32'(FAT_DEPTH), 32'd100);
        send_locate(32'hFFFF_FFFF, 32'd100);
        // next link below the first data cluster
        send_write(16'd4, 32'd1);
        send_locate(32'd4, 32'd10);
        send_write(16'd8, 32'd0);
        send_locate(32'd8, 32'd10);
        // next link past the table but under the end threshold
        send_write(16'd5, 32'(FAT_DEPTH));
        send_locate(32'd5, 32'd10);
        send_write(16'd6, EOC_RESET - 32'd1);
        send_locate(32'd6, 32'd10);
    endtask

    // A self-loop never meets the end threshold: walk stops at table size
    task automatic test_chain_too_long();
        send_write(16'd7, 32'd7);
        send_locate(32'd7, 32'd5000);
        send_write(16'd7, 32'hFFFF_FFFF);
    endtask

    // Random traffic under a range of geometries, extremes included
    task automatic test_geometry_sweep();
        run_phase(32'd512, 32'd8, 32'd0, 32'h0FFF_FFF8, 150, 1'b1);
        run_phase(32'd4096, 32'd128, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 120, 1'b0);
        run_phase(32'd512, 32'd1, 32'd1000, 32'd2, 90, 1'b1);
        run_phase(32'd0, 32'd8, 32'd7777, 32'h0FFF_FFF8, 80, 1'b1);
        run_phase(32'd8191, 32'd255, 32'hFFFF_0000, 32'h0001_0000, 120, 1'b0);
        run_phase(32'd4096, 32'd0, 32'd0, 32'd0, 70, 1'b1);
        run_phase(32'd2048, 32'd16, 32'd123456, 32'h0FFF_FFF8, 150, 1'b1);
        run_phase($urandom_range(8191, 1), $urandom_range(255, 1), $urandom,
                  $urandom_range(400, 2), 140, 1'b1);
    endtask

    // Result checker: every strobed word against the oldest expectation
    always @(posedge clk)
    begin : result_check
        slack_report_t want;
        if (rst_n && done)
        begin
            if (expected_reports.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result word, status expected none actual %0d",
                         $time, status);
            end
            else
            begin
                want = expected_reports.pop_front();
                compare_field("status", 64'(want.st), 64'(status));
                compare_field("last_cluster", 64'(want.last), 64'(last_cluster));
                compare_field("chain_length", 64'(want.len), 64'(chain_length));
                compare_field("slack_byte_offset", 64'(want.ofs), 64'(slack_byte_offset));
                compare_field("slack_bytes", 64'(want.spare), 64'(slack_bytes));
                compare_field("slack_offset_in_cluster", 64'(want.clu_rem),
                              64'(slack_offset_in_cluster));
            end
        end
    end

    // Watchdog: too long with no word taken in either direction
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d words outstanding", $time,
                     expected_reports.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_access();
        test_directed_items();
        test_chain_too_long();
        test_geometry_sweep();
        drain_block();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
